/* src/tile_neighbourhood_index_gen_assert.svh */
// Assertion macros for the checker file of this block.
`ifndef TILE_NEIGHBOURHOOD_INDEX_GEN_ASSERT_SVH
`define TILE_NEIGHBOURHOOD_INDEX_GEN_ASSERT_SVH

// Concurrent assertion on a named clock, switched off while the named reset is low.
`define TNG_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// The usual form, on the block clock and reset.
`define TNG_ASSERT(label, prop, msg) \
  `TNG_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

/* src/tng_pkg.sv */
package tng_pkg;

  localparam int unsigned CfgW  = 4;
  localparam int unsigned AddrW = 3;
  localparam int unsigned DataW = 32;
  localparam int unsigned LonW  = 9;
  localparam int unsigned LatW  = 8;
  localparam int unsigned SubW  = 3;
  localparam int unsigned IdxW  = LonW + LatW + 2 * SubW;

  localparam logic [CfgW-1:0] GridReset = 4'd7;

  // Angular constants, in whole degrees.
  localparam int LonHalf = 180;
  localparam int LonTurn = 360;
  localparam int LatHalf = 90;

  // Register index, taken from the word address bit.
  localparam logic RegGridWidth  = 1'b0;
  localparam logic RegGridHeight = 1'b1;

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StRun  = 2'b10
  } state_e;

  typedef struct packed {
    logic ready;
    logic emit;
    logic last;
  } seq_ctrl_t;

endpackage

/* src/tng_cfg.sv */
module tng_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tng_pkg::AddrW-1:0]  paddr,
  input  logic [tng_pkg::DataW-1:0]  pwdata,
  output logic [tng_pkg::DataW-1:0]  prdata,
  output logic                       pready,
  output logic [tng_pkg::CfgW-1:0]   grid_width_o,
  output logic [tng_pkg::CfgW-1:0]   grid_height_o
);
  import tng_pkg::*;

  logic [CfgW-1:0] grid_width_q;
  logic [CfgW-1:0] grid_height_q;
  logic            reg_sel;
  logic            wr_en;

  assign reg_sel = paddr[AddrW-1];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= GridReset;
      grid_height_q <= GridReset;
    end else if (wr_en) begin
      case (reg_sel)
        RegGridWidth:  grid_width_q  <= pwdata[CfgW-1:0];
        RegGridHeight: grid_height_q <= pwdata[CfgW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      RegGridWidth:  prdata = {{(DataW-CfgW){1'b0}}, grid_width_q};
      RegGridHeight: prdata = {{(DataW-CfgW){1'b0}}, grid_height_q};
      default:       prdata = '0;
    endcase
  end

  assign grid_width_o  = grid_width_q;
  assign grid_height_o = grid_height_q;

endmodule

/* src/tng_cell.sv */
module tng_cell #(
  parameter int unsigned CntW = 4
) (
  input  logic signed [tng_pkg::LonW-1:0] lon_i,
  input  logic signed [tng_pkg::LatW-1:0] lat_i,
  input  logic [tng_pkg::SubW-1:0]        col_i,
  input  logic [tng_pkg::SubW-1:0]        row_i,
  input  logic [CntW-1:0]                 col_ofs_i,
  input  logic [CntW-1:0]                 row_ofs_i,
  input  logic [CntW-1:0]                 half_w_i,
  input  logic [CntW-1:0]                 half_h_i,
  output logic [tng_pkg::IdxW-1:0]        index_o
);
  import tng_pkg::*;

  localparam int unsigned SumW  = ((SubW > CntW) ? SubW : CntW) + 2;
  localparam int unsigned LonSW = LonW + 2;
  localparam int unsigned LatSW = LatW + 2;

  localparam logic signed [LonSW-1:0] LonBias  = LonSW'(LonHalf);
  localparam logic signed [LonSW-1:0] LonWrap  = LonSW'(LonTurn);
  localparam logic [LonW-1:0]         LonFlip  = LonW'(LonHalf);
  localparam logic [LonW-1:0]         LonRest  = LonW'(LonTurn - LonHalf);
  localparam logic signed [LatSW-1:0] LatNorth = LatSW'(LatHalf);
  localparam logic signed [LatSW-1:0] LatSouth = LatSW'(-LatHalf);
  localparam logic signed [LatSW-1:0] LatNRefl = LatSW'(2 * LatHalf - 1);
  localparam logic signed [LatSW-1:0] LatSRefl = LatSW'(-(2 * LatHalf + 1));
  localparam logic signed [LatSW-1:0] LatBias  = LatSW'(LatHalf);

  logic signed [SumW-1:0]  dx;
  logic signed [SumW-1:0]  dy;
  logic signed [1:0]       cx;
  logic signed [1:0]       cy;
  logic signed [LonSW-1:0] lon_s;
  logic [LonW-1:0]         lon_u;
  logic [LonW-1:0]         lon_f;
  logic signed [LatSW-1:0] lat_s;
  logic signed [LatSW-1:0] lat_r;
  logic signed [LatSW-1:0] lat_b;
  logic                    north;
  logic                    south;
  logic                    flip;
  logic [SubW-1:0]         row_f;

  // Sub-cell sums; the bits above the sub-cell carry into whole degrees.
  assign dx = SumW'(col_i) + SumW'(col_ofs_i) - SumW'(half_w_i);
  assign dy = SumW'(row_i) + SumW'(row_ofs_i) - SumW'(half_h_i);
  assign cx = dx[SubW+1:SubW];
  assign cy = dy[SubW+1:SubW];

  assign lon_s = LonSW'(lon_i) + LonBias + LonSW'(cx);

  always_comb begin
    if (lon_s < 0) begin
      lon_u = LonW'(lon_s + LonWrap);
    end else if (lon_s >= LonWrap) begin
      lon_u = LonW'(lon_s - LonWrap);
    end else begin
      lon_u = LonW'(lon_s);
    end
  end

  assign lat_s = LatSW'(lat_i) + LatSW'(cy);
  assign north = (lat_s >= LatNorth);
  assign south = (lat_s < LatSouth);
  assign flip  = north | south;

  always_comb begin
    if (north) begin
      lat_r = LatNRefl - lat_s;
    end else if (south) begin
      lat_r = LatSRefl - lat_s;
    end else begin
      lat_r = lat_s;
    end
  end

  assign lat_b = lat_r + LatBias;

  // A pole crossing turns the longitude half way round and mirrors the row.
  always_comb begin
    if (!flip) begin
      lon_f = lon_u;
    end else if (lon_u >= LonFlip) begin
      lon_f = lon_u - LonFlip;
    end else begin
      lon_f = lon_u + LonRest;
    end
  end

  assign row_f   = flip ? ~dy[SubW-1:0] : dy[SubW-1:0];
  assign index_o = {lon_f, lat_b[LatW-1:0], row_f, dx[SubW-1:0]};

endmodule

/* src/tng_seq.sv */
module tng_seq #(
  parameter int unsigned CntW = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               out_free_i,
  input  logic [CntW-1:0]    grid_w_i,
  input  logic [CntW-1:0]    grid_h_i,
  output tng_pkg::seq_ctrl_t ctrl_o,
  output logic [CntW-1:0]    col_ofs_o,
  output logic [CntW-1:0]    row_ofs_o
);
  import tng_pkg::*;

  state_e          state_q, state_d;
  logic [CntW-1:0] col_q, col_d;
  logic [CntW-1:0] row_q, row_d;
  logic            ready;
  logic            accept;
  logic            emit;
  logic            col_end;
  logic            row_end;
  logic            empty;

  assign ready   = (state_q == StIdle);
  assign accept  = in_valid_i & ready;
  assign emit    = (state_q == StRun) & out_free_i;
  assign col_end = (col_q == CntW'(grid_w_i - 1'b1));
  assign row_end = (row_q == CntW'(grid_h_i - 1'b1));
  assign empty   = (grid_w_i == '0) | (grid_h_i == '0);

  always_comb begin
    state_d = state_q;
    col_d   = col_q;
    row_d   = row_q;
    case (state_q)
      StIdle: begin
        // An empty neighbourhood is taken and produces nothing.
        if (accept && !empty) begin
          state_d = StRun;
          col_d   = '0;
          row_d   = '0;
        end
      end
      StRun: begin
        if (emit) begin
          if (col_end && row_end) begin
            state_d = StIdle;
          end else if (col_end) begin
            col_d = '0;
            row_d = row_q + 1'b1;
          end else begin
            col_d = col_q + 1'b1;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      col_q   <= '0;
      row_q   <= '0;
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
      row_q   <= row_d;
    end
  end

  assign ctrl_o.ready = ready;
  assign ctrl_o.emit  = emit;
  assign ctrl_o.last  = col_end & row_end;
  assign col_ofs_o    = col_q;
  assign row_ofs_o    = row_q;

endmodule

/* src/tile_neighbourhood_index_gen.sv */
// Channel   | Direction | Handshake                 | Payload
// ----------+-----------+---------------------------+----------------------------------------
// config    | in/out    | psel, penable, pready     | paddr, pwrite, pwdata, prdata
// centre    | in        | in_valid_i, in_ready_o    | center_lon_i, center_lat_i, center_col_i,
//           |           |                           | center_row_i
// index     | out       | out_valid_o, out_ready_i  | tile_index_o, last_o
//
// The cell unit produces one index per cycle for each centre request that is taken,
// width x height indices in all (49 for the reset 7x7 grid), when the output is not stalled.
// The block takes the next request in the cycle after the last index enters the output
// register, while that index may still be waiting downstream.
// A stalled output holds the cell sequencer in place; nothing is lost or repeated.
// A grid of zero width or height takes the request and produces no index.
// Reset is asynchronous and active low; both grid registers reset to 7.
module tile_neighbourhood_index_gen #(
  parameter int unsigned MAX_GRID = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tng_pkg::AddrW-1:0]       paddr,
  input  logic [tng_pkg::DataW-1:0]       pwdata,
  output logic [tng_pkg::DataW-1:0]       prdata,
  output logic                            pready,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic signed [tng_pkg::LonW-1:0] center_lon_i,
  input  logic signed [tng_pkg::LatW-1:0] center_lat_i,
  input  logic [tng_pkg::SubW-1:0]        center_col_i,
  input  logic [tng_pkg::SubW-1:0]        center_row_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [tng_pkg::IdxW-1:0]        tile_index_o,
  output logic                            last_o
);
  import tng_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_GRID + 1);

  logic [CfgW-1:0]         grid_width;
  logic [CfgW-1:0]         grid_height;
  logic [CntW-1:0]         grid_w;
  logic [CntW-1:0]         grid_h;
  logic [CntW-1:0]         col_ofs;
  logic [CntW-1:0]         row_ofs;
  logic [IdxW-1:0]         index;
  logic                    out_free;
  logic                    accept;
  seq_ctrl_t               ctrl;

  logic signed [LonW-1:0]  lon_q;
  logic signed [LatW-1:0]  lat_q;
  logic [SubW-1:0]         col_q;
  logic [SubW-1:0]         row_q;
  logic                    out_valid_q;
  logic [IdxW-1:0]         tile_index_q;
  logic                    last_q;

  tng_cfg u_cfg (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .grid_width_o  (grid_width),
    .grid_height_o (grid_height)
  );

  // Register values above the largest grid saturate to it.
  assign grid_w = (grid_width > CfgW'(MAX_GRID)) ? CntW'(MAX_GRID) : CntW'(grid_width);
  assign grid_h = (grid_height > CfgW'(MAX_GRID)) ? CntW'(MAX_GRID) : CntW'(grid_height);

  assign out_free = ~out_valid_q | out_ready_i;

  tng_seq #(
    .CntW (CntW)
  ) u_seq (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .out_free_i (out_free),
    .grid_w_i   (grid_w),
    .grid_h_i   (grid_h),
    .ctrl_o     (ctrl),
    .col_ofs_o  (col_ofs),
    .row_ofs_o  (row_ofs)
  );

  tng_cell #(
    .CntW (CntW)
  ) u_cell (
    .lon_i     (lon_q),
    .lat_i     (lat_q),
    .col_i     (col_q),
    .row_i     (row_q),
    .col_ofs_i (col_ofs),
    .row_ofs_i (row_ofs),
    .half_w_i  (grid_w >> 1),
    .half_h_i  (grid_h >> 1),
    .index_o   (index)
  );

  assign in_ready_o = ctrl.ready;
  assign accept     = in_valid_i & ctrl.ready;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      lon_q <= center_lon_i;
      lat_q <= center_lat_i;
      col_q <= center_col_i;
      row_q <= center_row_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.emit) begin
      tile_index_q <= index;
      last_q       <= ctrl.last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign tile_index_o = tile_index_q;
  assign last_o       = last_q;

endmodule

/* src/tng_checker.sv */
`include "tile_neighbourhood_index_gen_assert.svh"

module tng_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            psel,
  input logic                            penable,
  input logic                            pwrite,
  input logic [tng_pkg::AddrW-1:0]       paddr,
  input logic [tng_pkg::DataW-1:0]       pwdata,
  input logic [tng_pkg::DataW-1:0]       prdata,
  input logic                            pready,
  input logic                            in_ready_o,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic [tng_pkg::IdxW-1:0]        tile_index_o,
  input logic                            last_o
);

  // A stalled index stays offered.
  `TNG_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o, "index dropped while stalled")

  // A stalled index keeps its value and its end flag.
  `TNG_ASSERT(a_out_stable, out_valid_o && !out_ready_i |=> $stable(tile_index_o) && $stable(last_o), "stalled index changed")

  // While an index other than the last waits, the neighbourhood is unfinished.
  `TNG_ASSERT(a_busy_mid_grid, out_valid_o && !last_o |-> !in_ready_o, "new centre taken mid neighbourhood")

  // A register read straight after a write returns the written grid size.
  `TNG_ASSERT(a_cfg_readback, (psel && penable && pwrite && pready) ##1 (psel && !pwrite && (paddr[2] == $past(paddr[2]))) |-> (prdata[3:0] == $past(pwdata[3:0])), "grid register readback mismatch")

endmodule

bind tile_neighbourhood_index_gen tng_checker u_tng_checker (.*);

/* test/tb_tile_neighbourhood_index_gen.sv */
`timescale 1ns / 100ps

module tb_tile_neighbourhood_index_gen;
  import tng_pkg::*;

  localparam int unsigned MaxGrid     = 8;
  localparam int unsigned QuietCycles = 80;
  localparam int unsigned StallLimit  = 4000;
  localparam int unsigned MaxPrinted  = 30;
  localparam int unsigned ReconfEvery = 12;

  typedef struct packed {
    logic [IdxW-1:0] tile_index;
    logic            last;
  } cell_t;

  logic                   clk_i        = 1'b0;
  logic                   rst_ni       = 1'b0;
  logic                   psel         = 1'b0;
  logic                   penable      = 1'b0;
  logic                   pwrite       = 1'b0;
  logic [AddrW-1:0]       paddr        = '0;
  logic [DataW-1:0]       pwdata       = '0;
  logic [DataW-1:0]       prdata;
  logic                   pready;
  logic                   in_valid_i   = 1'b0;
  logic                   in_ready_o;
  logic signed [LonW-1:0] center_lon_i = '0;
  logic signed [LatW-1:0] center_lat_i = '0;
  logic [SubW-1:0]        center_col_i = '0;
  logic [SubW-1:0]        center_row_i = '0;
  logic                   out_valid_o;
  logic                   out_ready_i  = 1'b0;
  logic [IdxW-1:0]        tile_index_o;
  logic                   last_o;

  logic [CfgW-1:0] grid_w_model = GridReset;
  logic [CfgW-1:0] grid_h_model = GridReset;
  cell_t           expected_cells[$];
  int unsigned     send_idle_pct  = 0;
  int unsigned     recv_stall_pct = 0;
  int unsigned     n_centres      = 0;
  int unsigned     n_cells        = 0;
  int unsigned     n_writes       = 0;
  int unsigned     n_errors       = 0;
  int unsigned     quiet_count    = 0;

  tile_neighbourhood_index_gen #(
    .MAX_GRID(MaxGrid)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .center_lon_i(center_lon_i),
    .center_lat_i(center_lat_i),
    .center_col_i(center_col_i),
    .center_row_i(center_row_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .tile_index_o(tile_index_o),
    .last_o      (last_o)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  task automatic report_mismatch(string what);
    if (n_errors < MaxPrinted) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
    n_errors++;
  endtask

  // Floor modulo into -180..179.
  function automatic int wrap_lon(int v);
    int r;
    r = (v + LonHalf) % LonTurn;
    if (r < 0) begin
      r += LonTurn;
    end
    return r - LonHalf;
  endfunction

  function automatic void predict_neighbourhood(logic signed [LonW-1:0] lon_c,
                                                logic signed [LatW-1:0] lat_c,
                                                logic [SubW-1:0] col_c,
                                                logic [SubW-1:0] row_c);
    int    w, h, dx, dy, cx, cy, col, row, lon, lat;
    cell_t exp_cell;
    w = (grid_w_model > MaxGrid) ? MaxGrid : int'(grid_w_model);
    h = (grid_h_model > MaxGrid) ? MaxGrid : int'(grid_h_model);
    for (int j = 0; j < h; j++) begin
      for (int i = 0; i < w; i++) begin
        dx  = int'(col_c) + i - w / 2;
        dy  = int'(row_c) + j - h / 2;
        // An arithmetic shift is floor division by eight, negative offsets included.
        cx  = dx >>> SubW;
        cy  = dy >>> SubW;
        col = dx & 7;
        row = dy & 7;
        lon = wrap_lon(int'(lon_c) + cx);
        lat = int'(lat_c) + cy;
        // Crossing a pole reflects latitude, turns longitude half way round and mirrors the row.
        if (lat >= LatHalf) begin
          lat = 2 * LatHalf - 1 - lat;
          lon = wrap_lon(lon + LonHalf);
          row = 7 - row;
        end
        if (lat < -LatHalf) begin
          lat = -2 * LatHalf - 1 - lat;
          lon = wrap_lon(lon + LonHalf);
          row = 7 - row;
        end
        exp_cell.tile_index = IdxW'(((lon + LonHalf) << (LatW + 2 * SubW))
                              + ((lat + LatHalf) << (2 * SubW)) + (row << SubW) + col);
        exp_cell.last = (j == h - 1) && (i == w - 1);
        expected_cells.push_back(exp_cell);
      end
    end
  endfunction

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin : check_cells
    cell_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_cells++;
      if (expected_cells.size() == 0) begin
        report_mismatch($sformatf("index %0d arrived with no request outstanding",
                                  tile_index_o));
      end else begin
        want = expected_cells.pop_front();
        if (tile_index_o !== want.tile_index) begin
          report_mismatch($sformatf("tile_index %0d, expected %0d", tile_index_o,
                                    want.tile_index));
        end
        if (last_o !== want.last) begin
          report_mismatch($sformatf("last %b, expected %b (index %0d)", last_o, want.last,
                                    want.tile_index));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (psel && penable && pready)) begin
        quiet_count <= 0;
      end else begin
        quiet_count <= quiet_count + 1;
      end
      if (quiet_count >= StallLimit) begin
        $display("Watchdog: no progress for %0d cycles, %0d indices still expected",
                 StallLimit, expected_cells.size());
        $display("tile_neighbourhood_index_gen regression: fail");
        $finish;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the request is taken.
  // Valid stays high on return so that a following request can follow without a gap.
  task automatic send_centre(logic signed [LonW-1:0] lon, logic signed [LatW-1:0] lat,
                             logic [SubW-1:0] col, logic [SubW-1:0] row);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    center_lon_i <= lon;
    center_lat_i <= lat;
    center_col_i <= col;
    center_row_i <= row;
    do @(posedge clk_i); while (!in_ready_o);
    predict_neighbourhood(lon, lat, col, row);
    n_centres++;
    @(negedge clk_i);
  endtask

  // A request on an empty grid yields nothing, so the block is given time to settle as well.
  task automatic drain_indices();
    in_valid_i <= 1'b0;
    while (expected_cells.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (QuietCycles) @(negedge clk_i);
  endtask

  task automatic write_grid(logic sel, logic [CfgW-1:0] value);
    logic [DataW-1:0] readback;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= DataW'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (sel == RegGridWidth) begin
      grid_w_model = value;
    end else begin
      grid_h_model = value;
    end
    n_writes++;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    readback = prdata;
    if (readback[CfgW-1:0] !== value) begin
      report_mismatch($sformatf("register %0d read %0d, written %0d", sel,
                                readback[CfgW-1:0], value));
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic configure_grid(logic [CfgW-1:0] w, logic [CfgW-1:0] h);
    drain_indices();
    write_grid(RegGridWidth, w);
    write_grid(RegGridHeight, h);
  endtask

  function automatic logic [CfgW-1:0] pick_grid();
    // Mostly legal sizes, now and then an empty or oversized one.
    if ($urandom_range(99) < 12) begin
      return CfgW'($urandom_range(15));
    end
    return CfgW'($urandom_range(MaxGrid, 1));
  endfunction

  // Reset 7x7 grid: longitude and latitude extremes, both poles, corner sub-cells.
  task automatic test_reset_grid();
    send_centre(-180, 0, 0, 0);
    send_centre(179, 0, 7, 7);
    send_centre(-256, 89, 3, 7);
    send_centre(255, -90, 4, 0);
    send_centre(0, 127, 0, 0);
    send_centre(0, -128, 7, 7);
    send_centre(100, -91, 2, 5);
    send_centre(-100, 90, 5, 2);
    send_centre(0, 0, 3, 3);
  endtask

  // Single cell, full grid, oversized, empty and lopsided grids.
  task automatic test_grid_sizes();
    configure_grid(1, 1);
    send_centre(179, 89, 7, 7);
    configure_grid(MaxGrid, MaxGrid);
    send_centre(-180, -90, 0, 0);
    send_centre(179, 89, 7, 7);
    configure_grid(15, 9);
    send_centre(-1, -1, 0, 7);
    configure_grid(0, 5);
    send_centre(10, 10, 1, 1);
    configure_grid(5, 0);
    send_centre(-10, -10, 6, 6);
    configure_grid(0, 0);
    send_centre(0, 0, 0, 0);
    configure_grid(MaxGrid, 1);
    send_centre(-180, 45, 0, 4);
    configure_grid(1, MaxGrid);
    send_centre(179, -90, 7, 0);
    configure_grid(2, 3);
    send_centre(255, 127, 7, 7);
    configure_grid(15, 15);
    send_centre(-256, -128, 0, 0);
  endtask

  task automatic test_random_traffic(int unsigned idle_pct, int unsigned stall_pct,
                                     int unsigned n_items);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int k = 0; k < n_items; k++) begin
      if (k % ReconfEvery == 0) begin
        configure_grid(pick_grid(), pick_grid());
      end
      send_centre(LonW'($urandom), LatW'($urandom), SubW'($urandom), SubW'($urandom));
    end
    drain_indices();
  endtask

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_reset_grid();
    test_grid_sizes();
    test_random_traffic(0, 0, 63);
    test_random_traffic(86, 0, 63);
    test_random_traffic(0, 86, 63);
    test_random_traffic(37, 37, 63);
    drain_indices();
    if (expected_cells.size() != 0) begin
      report_mismatch($sformatf("%0d indices never arrived", expected_cells.size()));
    end
    $display("Sent %0d centre requests, checked %0d indices, made %0d grid register writes.",
             n_centres, n_cells, n_writes);
    $display("Grids ranged from empty to oversized, under free flow, idle sender, stalling"
             , " receiver and both together; %0d mismatches.", n_errors);
    if (n_errors == 0) begin
      $display("tile_neighbourhood_index_gen regression: pass");
    end else begin
      $display("tile_neighbourhood_index_gen regression: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+src
src/tng_pkg.sv
src/tng_cfg.sv
src/tng_cell.sv
src/tng_seq.sv
src/tile_neighbourhood_index_gen.sv
src/tng_checker.sv
test/tb_tile_neighbourhood_index_gen.sv
